@@ rtl/rv32ite_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32ite_pkg
// Shared types and constants for the RV32I I-type execute block.
// ----------------------------------------------------------------------------
package rv32ite_pkg;

  localparam int XLEN          = 32;
  localparam int REG_CNT       = 32;
  localparam int REG_IDX_W     = 5;
  localparam int IMM_W         = 12;
  localparam int PADDR_W       = 12;
  localparam int BYTE_W        = 8;
  localparam int BANKS         = 4;
  localparam int PC_STEP       = 4;
  localparam int SHAMT_W       = 5;
  localparam int MEM_ADDR_BITS_DEF = 12;
  localparam int CMD_Q_DEPTH   = 4;
  localparam int RES_Q_DEPTH   = 2;

  typedef enum logic [3:0] {
    OP_JALR  = 4'd0,
    OP_LB    = 4'd1,
    OP_LH    = 4'd2,
    OP_LW    = 4'd3,
    OP_LBU   = 4'd4,
    OP_LHU   = 4'd5,
    OP_ADDI  = 4'd6,
    OP_SLTI  = 4'd7,
    OP_SLTIU = 4'd8,
    OP_XORI  = 4'd9,
    OP_ORI   = 4'd10,
    OP_ANDI  = 4'd11,
    OP_SLLI  = 4'd12,
    OP_SRLI  = 4'd13,
    OP_SRAI  = 4'd14,
    OP_MEMWR = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } ld_size_t;

  typedef struct packed {
    op_t      op;
    logic     is_load;
    logic     is_store;
    logic     is_jalr;
    ld_size_t size;
    logic     ld_unsigned;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs;
    logic [IMM_W-1:0]     imm;
    logic [PADDR_W-1:0]   paddr;
    logic [BYTE_W-1:0]    pbyte;
  } cmd_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      value;
    logic                 done;
    logic [XLEN-1:0]      npc;
  } res_t;

endpackage

@@ rtl/rv32ite_fifo.sv @@
// ----------------------------------------------------------------------------
// rv32ite_fifo
// Small register queue with full and empty flags; push and pop may share a cycle when it is neither empty nor full.
// ----------------------------------------------------------------------------
module rv32ite_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/rv32ite_front.sv @@
// ----------------------------------------------------------------------------
// rv32ite_front
// Accepts instruction beats, decodes the opcode and queues decoded commands.
// ----------------------------------------------------------------------------
module rv32ite_front import rv32ite_pkg::*; #(
  parameter int DEPTH = CMD_Q_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      hold,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [3:0]                in_op,
  input  logic [REG_IDX_W-1:0]      in_dest_index,
  input  logic [REG_IDX_W-1:0]      in_source_index,
  input  logic signed [IMM_W-1:0]   in_immediate,
  input  logic [PADDR_W-1:0]        in_preload_address,
  input  logic [BYTE_W-1:0]         in_preload_byte,
  input  logic                      q_pop,
  output cmd_t                      q_cmd,
  output logic                      q_empty
);

  ctl_t ctl;
  cmd_t cmd;
  logic q_full;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    ctl             = '0;
    ctl.op          = op_t'(in_op);
    ctl.size        = SZ_WORD;
    unique case (op_t'(in_op)) inside
      OP_JALR: begin
        ctl.is_jalr = 1'b1;
      end
      OP_LB, OP_LBU: begin
        ctl.is_load     = 1'b1;
        ctl.size        = SZ_BYTE;
        ctl.ld_unsigned = (op_t'(in_op) == OP_LBU);
      end
      OP_LH, OP_LHU: begin
        ctl.is_load     = 1'b1;
        ctl.size        = SZ_HALF;
        ctl.ld_unsigned = (op_t'(in_op) == OP_LHU);
      end
      OP_LW: begin
        ctl.is_load = 1'b1;
      end
      OP_MEMWR: begin
        ctl.is_store = 1'b1;
      end
      default: begin
        ctl.is_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.ctl   = ctl;
    cmd.rd    = in_dest_index;
    cmd.rs    = in_source_index;
    cmd.imm   = in_immediate;
    cmd.paddr = in_preload_address;
    cmd.pbyte = in_preload_byte;
  end

  // hold keeps the queue closed while memory is being cleared
  assign in_full = q_full || hold;
  assign q_cmd   = cmd_t'(q_rdata);

  rv32ite_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !hold),
    .wdata (cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

endmodule

@@ rtl/rv32ite_back.sv @@
// ----------------------------------------------------------------------------
// rv32ite_back
// Two-stage execute: register read, ALU and memory access, then load
// alignment, register writeback and result.
// ----------------------------------------------------------------------------
module rv32ite_back import rv32ite_pkg::*; #(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic clr_busy,
  output logic res_push,
  output res_t res,
  input  logic res_full
);

  localparam int ROW_BITS = MEM_ADDR_BITS - 2;
  localparam int ROWS     = 1 << ROW_BITS;

  // architectural state
  logic [XLEN-1:0]     rf_r [REG_CNT];
  logic [XLEN-1:0]     pc_r, pc_nxt;

  // clearing pass
  logic                clr_busy_r;
  logic [ROW_BITS-1:0] clr_row_r;

  // stage 2 registers
  logic                 e2_valid_r;
  ctl_t                 e2_ctl_r;
  logic [REG_IDX_W-1:0] e2_rd_r;
  logic                 e2_wr_r;
  logic [XLEN-1:0]      e2_alu_r;
  logic [1:0]           e2_lo_r;
  logic [XLEN-1:0]      e2_npc_r;

  logic                 e1_go, e2_go;
  logic                 fwd;
  logic [XLEN-1:0]      imm_ext, src_val, ea, alu, e1_npc;
  logic [SHAMT_W-1:0]   sh;
  logic [XLEN-1:0]      e2_value, ld_val;
  logic [BYTE_W-1:0]    ld_b [BANKS];
  logic [XLEN-1:0]      paddr_ext;
  logic [MEM_ADDR_BITS-1:0] st_addr;
  logic [MEM_ADDR_BITS-1:0] byte_addr [BANKS];

  logic                bank_we    [BANKS];
  logic [ROW_BITS-1:0] bank_waddr [BANKS];
  logic [BYTE_W-1:0]   bank_wdata [BANKS];
  logic [ROW_BITS-1:0] bank_raddr [BANKS];
  logic [BYTE_W-1:0]   bank_rdata [BANKS];
  logic                bank_re;

  assign clr_busy = clr_busy_r;
  assign e2_go    = e2_valid_r && !res_full;
  assign e1_go    = !q_empty && !clr_busy_r && (!e2_valid_r || e2_go);
  assign q_pop    = e1_go;
  assign res_push = e2_go;

  // stage 1: operand read with bypass from stage 2
  assign imm_ext = {{(XLEN-IMM_W){q_cmd.imm[IMM_W-1]}}, q_cmd.imm};
  assign fwd     = e2_valid_r && e2_wr_r && (e2_rd_r == q_cmd.rs);
  assign sh      = imm_ext[SHAMT_W-1:0];

  always_comb begin
    if (q_cmd.rs == '0) begin
      src_val = '0;
    end else if (fwd) begin
      src_val = e2_value;
    end else begin
      src_val = rf_r[q_cmd.rs];
    end
  end

  assign ea = src_val + imm_ext;

  always_comb begin
    case (q_cmd.ctl.op)
      OP_JALR:  alu = pc_r + XLEN'(PC_STEP);
      OP_ADDI:  alu = ea;
      OP_SLTI:  alu = XLEN'($signed(src_val) < $signed(imm_ext));
      OP_SLTIU: alu = XLEN'(src_val < imm_ext);
      OP_XORI:  alu = src_val ^ imm_ext;
      OP_ORI:   alu = src_val | imm_ext;
      OP_ANDI:  alu = src_val & imm_ext;
      OP_SLLI:  alu = src_val << sh;
      OP_SRLI:  alu = src_val >> sh;
      OP_SRAI:  alu = $unsigned($signed(src_val) >>> sh);
      default:  alu = '0;
    endcase
  end

  always_comb begin
    if (q_cmd.ctl.is_store) begin
      e1_npc = pc_r;
    end else if (q_cmd.ctl.is_jalr) begin
      e1_npc = {ea[XLEN-1:1], 1'b0};
    end else begin
      e1_npc = pc_r + XLEN'(PC_STEP);
    end
  end

  assign pc_nxt = (e1_go && !q_cmd.ctl.is_store) ? e1_npc : pc_r;

  // memory ports: byte banks interleaved on the low two address bits
  assign paddr_ext = XLEN'(q_cmd.paddr);
  assign st_addr   = paddr_ext[MEM_ADDR_BITS-1:0];
  assign bank_re   = e1_go && q_cmd.ctl.is_load;

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      // each bank serves the byte of the access that falls on it, wrapping
      byte_addr[b]  = ea[MEM_ADDR_BITS-1:0]
                    + MEM_ADDR_BITS'(2'(2'(b) - ea[1:0]));
      bank_raddr[b] = byte_addr[b][MEM_ADDR_BITS-1:2];
      if (clr_busy_r) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = clr_row_r;
        bank_wdata[b] = '0;
      end else begin
        bank_we[b]    = e1_go && q_cmd.ctl.is_store && (st_addr[1:0] == 2'(b));
        bank_waddr[b] = st_addr[MEM_ADDR_BITS-1:2];
        bank_wdata[b] = q_cmd.pbyte;
      end
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [BYTE_W-1:0] mem_r [ROWS];
    logic [BYTE_W-1:0] rdata_r;

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem_r[bank_waddr[b]] <= bank_wdata[b];
      end
      if (bank_re) begin
        rdata_r <= mem_r[bank_raddr[b]];
      end
    end

    assign bank_rdata[b] = rdata_r;
  end

  // stage 2: load alignment and extension
  always_comb begin
    for (int k = 0; k < BANKS; k++) begin
      ld_b[k] = bank_rdata[2'(e2_lo_r + 2'(k))];
    end
  end

  always_comb begin
    case (e2_ctl_r.size)
      SZ_BYTE: ld_val = e2_ctl_r.ld_unsigned ? XLEN'(ld_b[0])
                        : {{(XLEN-8){ld_b[0][7]}}, ld_b[0]};
      SZ_HALF: ld_val = e2_ctl_r.ld_unsigned ? XLEN'({ld_b[1], ld_b[0]})
                        : {{(XLEN-16){ld_b[1][7]}}, ld_b[1], ld_b[0]};
      default: ld_val = {ld_b[3], ld_b[2], ld_b[1], ld_b[0]};
    endcase
  end

  assign e2_value = e2_ctl_r.is_load ? ld_val : e2_alu_r;

  always_comb begin
    res     = '0;
    res.npc = e2_npc_r;
    if (!e2_ctl_r.is_store) begin
      res.idx   = e2_rd_r;
      res.value = e2_value;
      res.done  = (e2_rd_r != '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
      e2_valid_r <= 1'b0;
      pc_r       <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_row_r <= clr_row_r + 1'b1;
        if (clr_row_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (e1_go) begin
        e2_valid_r <= 1'b1;
      end else if (e2_go) begin
        e2_valid_r <= 1'b0;
      end
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REG_CNT; r++) begin
        rf_r[r] <= '0;
      end
    end else if (e2_go && e2_wr_r) begin
      rf_r[e2_rd_r] <= e2_value;
    end
  end

  always_ff @(posedge clk) begin
    if (e1_go) begin
      e2_ctl_r <= q_cmd.ctl;
      e2_rd_r  <= q_cmd.rd;
      e2_wr_r  <= !q_cmd.ctl.is_store && (q_cmd.rd != '0);
      e2_alu_r <= alu;
      e2_lo_r  <= ea[1:0];
      e2_npc_r <= e1_npc;
    end
  end

endmodule

@@ rtl/rv32i_itype_execute_top.sv @@
// ----------------------------------------------------------------------------
// rv32i_itype_execute_top
// RV32I I-type execute unit with register file, pc and byte data memory.
// ----------------------------------------------------------------------------
// Usage:
//   Instructions enter on a queue-style port: a beat is taken when in_push is
//   high and in_full is low. Results leave the same way: the oldest result is
//   on the out_ ports while out_empty is low and is taken when out_pop is high.
//   Every instruction beat, the memory byte write included, gives exactly one
//   result beat, in order.
//   Throughput is one beat per cycle while the result queue has room and the
//   memory is not being cleared; a load, or a use of the register a load just
//   wrote, does not stall, since the load data is bypassed from the second execute stage.
//   An accepted beat is held in the command queue, then in the second execute
//   stage registers, and is then written into the result queue, from which it
//   shows on the out_ ports.
//   After reset the data memory is cleared one 4-byte row per cycle, over all
//   2**(MEM_ADDR_BITS-2) rows (1024 at the default size); in_full stays high
//   until the last row is cleared. Register file and pc reset to zero.
//   When the receiver stops popping, the result queue fills, the execute
//   stages hold, then the command queue fills and in_full rises.
// ----------------------------------------------------------------------------
module rv32i_itype_execute_top import rv32ite_pkg::*; #(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
  parameter int CMD_DEPTH     = CMD_Q_DEPTH,
  parameter int RES_DEPTH     = RES_Q_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [3:0]               in_op,
  input  logic [REG_IDX_W-1:0]     in_dest_index,
  input  logic [REG_IDX_W-1:0]     in_source_index,
  input  logic signed [IMM_W-1:0]  in_immediate,
  input  logic [PADDR_W-1:0]       in_preload_address,
  input  logic [BYTE_W-1:0]        in_preload_byte,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [REG_IDX_W-1:0]     out_written_index,
  output logic signed [XLEN-1:0]   out_written_value,
  output logic                     out_write_done,
  output logic [XLEN-1:0]          out_next_pc
);

  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;
  logic clr_busy;
  logic res_push;
  res_t res;
  res_t res_head;
  logic res_full;
  logic [$bits(res_t)-1:0] res_rdata;

  rv32ite_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .hold               (clr_busy),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_op              (in_op),
    .in_dest_index      (in_dest_index),
    .in_source_index    (in_source_index),
    .in_immediate       (in_immediate),
    .in_preload_address (in_preload_address),
    .in_preload_byte    (in_preload_byte),
    .q_pop              (q_pop),
    .q_cmd              (q_cmd),
    .q_empty            (q_empty)
  );

  rv32ite_back #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .clr_busy (clr_busy),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  rv32ite_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_head          = res_t'(res_rdata);
  assign out_written_index = res_head.idx;
  assign out_written_value = $signed(res_head.value);
  assign out_write_done    = res_head.done;
  assign out_next_pc       = res_head.npc;

endmodule
